// ===== rtl/tbb_pkg.sv =====
`timescale 1ns / 1ps

package tbb_pkg;

  localparam int HS_W   = 31;            // half size width, unsigned Q15.16
  localparam int W_W    = 32;            // weight / offset / bound width
  localparam int PROD_W = W_W + HS_W;    // |w| * h, exact Q47.16
  localparam int SUM_W  = 64;            // sum of three products plus rounding
  localparam int FRAC_W = 16;
  localparam int EXT_W  = SUM_W - FRAC_W; // rounded extent, integer part of the Q48.16 sum
  localparam int BND_W  = EXT_W + 2;     // offset +/- extent before saturation

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

  typedef logic [1:0] axis_t;

  typedef enum logic [1:0] {
    REG_HALF_SIZE_X = 2'd0,
    REG_HALF_SIZE_Y = 2'd1,
    REG_HALF_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    axis_t              axis;
    logic signed [31:0] weight_x;
    logic signed [31:0] weight_y;
    logic signed [31:0] weight_z;
    logic signed [31:0] offset;
  } row_t;

  typedef struct packed {
    axis_t              axis_out;
    logic signed [31:0] bound_min;
    logic signed [31:0] bound_max;
  } bound_t;

  typedef struct packed {
    logic [HS_W-1:0] hx;
    logic [HS_W-1:0] hy;
    logic [HS_W-1:0] hz;
  } half_t;

  typedef struct packed {
    axis_t              axis;
    logic signed [31:0] offset;
    logic [EXT_W-1:0]   ext;
  } extent_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [W_W-1:0] sat32(input logic signed [BND_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[BND_W-1:W_W-1];
    hi_zeros = ~|v[BND_W-1:W_W-1];
    if (hi_ones || hi_zeros) begin
      return v[W_W-1:0];
    end else if (v[BND_W-1]) begin
      return {1'b1, {(W_W-1){1'b0}}};
    end else begin
      return {1'b0, {(W_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/tbb_if.sv =====
`timescale 1ns / 1ps

interface tbb_row_if;
  logic          valid;
  logic          ready;
  tbb_pkg::row_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tbb_bound_if;
  logic            valid;
  logic            ready;
  tbb_pkg::bound_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/tbb_extent.sv =====
`timescale 1ns / 1ps

module tbb_extent import tbb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  row_t    in_row,
  input  half_t   hs,
  output logic    out_valid,
  input  logic    out_ready,
  output extent_t out_ext
);

  // stage a: magnitudes
  logic               va;
  axis_t              axis_a;
  logic signed [31:0] off_a;
  logic [W_W-1:0]     mag_x, mag_y, mag_z;
  // stage b: products
  logic               vb;
  axis_t              axis_b;
  logic signed [31:0] off_b;
  logic [PROD_W-1:0]  prod_x, prod_y, prod_z;
  // stage c: partial sums
  logic               vc;
  axis_t              axis_c;
  logic signed [31:0] off_c;
  logic [SUM_W-1:0]   sum_xy, sum_zr;
  // stage d: rounded extent
  logic               vd;
  axis_t              axis_d;
  logic signed [31:0] off_d;
  logic [EXT_W-1:0]   ext_d;

  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic [SUM_W-1:0] sum_all;

  assign rdy_d    = !vd || out_ready;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  assign sum_all = sum_xy + sum_zr;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      axis_a <= in_row.axis;
      off_a  <= in_row.offset;
      mag_x  <= in_row.weight_x[W_W-1] ? (~in_row.weight_x + 1'b1) : in_row.weight_x;
      mag_y  <= in_row.weight_y[W_W-1] ? (~in_row.weight_y + 1'b1) : in_row.weight_y;
      mag_z  <= in_row.weight_z[W_W-1] ? (~in_row.weight_z + 1'b1) : in_row.weight_z;
    end
    if (rdy_b && va) begin
      axis_b <= axis_a;
      off_b  <= off_a;
      prod_x <= PROD_W'(mag_x) * PROD_W'(hs.hx);
      prod_y <= PROD_W'(mag_y) * PROD_W'(hs.hy);
      prod_z <= PROD_W'(mag_z) * PROD_W'(hs.hz);
    end
    if (rdy_c && vb) begin
      axis_c <= axis_b;
      off_c  <= off_b;
      sum_xy <= SUM_W'(prod_x) + SUM_W'(prod_y);
      sum_zr <= SUM_W'(prod_z) + ROUND_HALF;
    end
    if (rdy_d && vc) begin
      axis_d <= axis_c;
      off_d  <= off_c;
      ext_d  <= sum_all[SUM_W-1:FRAC_W];
    end
  end

  assign out_valid      = vd;
  assign out_ext.axis   = axis_d;
  assign out_ext.offset = off_d;
  assign out_ext.ext    = ext_d;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !va && !vb && !vc && !vd)
    else $error("extent pipeline not empty after reset");
  a_enter: assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> va)
    else $error("accepted request did not enter first stage");
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
      vd && !out_ready |=> vd && $stable(ext_d) && $stable(off_d))
    else $error("last stage changed while stalled");
  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
      vc && !rdy_d |=> vc && $stable(sum_xy) && $stable(sum_zr))
    else $error("sum stage changed while stalled");
`endif

endmodule

// ===== rtl/transformed_box_bounds.sv =====
`timescale 1ns / 1ps
// Five stages: magnitudes, products, partial sums, rounded extent and the output bounds.
// One row per cycle unless stalled; the three 32x31 multipliers of stage two set the pace.
// Each stage stalls on its own, so bubbles close up while the output waits.
// Reset (synchronous, rst high) empties the pipeline and clears all half sizes to zero.

module transformed_box_bounds import tbb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [1:0]      wr_index,
  input  logic [HS_W-1:0] wr_data,
  tbb_row_if.sink         rows,
  tbb_bound_if.source     bounds
);

  half_t   hs;
  logic    xv;
  logic    x_ready;
  extent_t xe;

  logic               ov;
  bound_t             ob;
  logic               o_ready;
  logic signed [BND_W-1:0] off_w;
  logic signed [BND_W-1:0] ext_w;
  logic signed [BND_W-1:0] lo_w;
  logic signed [BND_W-1:0] hi_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      hs <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_HALF_SIZE_X: hs.hx <= wr_data;
        REG_HALF_SIZE_Y: hs.hy <= wr_data;
        REG_HALF_SIZE_Z: hs.hz <= wr_data;
        default: ;
      endcase
    end
  end

  tbb_extent u_extent (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rows.valid),
    .in_ready (rows.ready),
    .in_row   (rows.payload),
    .hs       (hs),
    .out_valid(xv),
    .out_ready(x_ready),
    .out_ext  (xe)
  );

  assign o_ready = !ov || bounds.ready;
  assign x_ready = o_ready;

  assign off_w = BND_W'(xe.offset);
  assign ext_w = $signed({2'b00, xe.ext});
  assign lo_w  = off_w - ext_w;
  assign hi_w  = off_w + ext_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (o_ready) begin
      ov <= xv;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && xv) begin
      ob.axis_out  <= xe.axis;
      ob.bound_min <= sat32(lo_w);
      ob.bound_max <= sat32(hi_w);
    end
  end

  assign bounds.valid   = ov;
  assign bounds.payload = ob;

`ifndef SYNTHESIS
  a_reset_idle: assert property (@(posedge clk) rst |=> !bounds.valid)
    else $error("output valid after reset");
  a_ordered: assert property (@(posedge clk) disable iff (rst)
      bounds.valid |-> ob.bound_min <= ob.bound_max)
    else $error("bound_min above bound_max");
  a_handover: assert property (@(posedge clk) disable iff (rst)
      xv && o_ready |=> bounds.valid)
    else $error("extent request lost at output stage");
`endif

endmodule
